[src/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit block allocator
// Sizes, item codes, response kinds and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Size of the allocation table and the widths that follow from it.
  localparam int BLOCK_COUNT = 128;
  localparam int BLK_W       = $clog2(BLOCK_COUNT);
  localparam int CNT_W       = BLK_W + 1;
  localparam int LINK_W      = 8;

  // Link value that marks the end of a chain.
  localparam logic [LINK_W-1:0] LINK_END = '1;

  // Reset value of the blocks-in-use register.
  localparam logic [7:0] BLOCKS_IN_USE_RST = 8'd128;

  // Register index of blocks_in_use (address bit 2).
  localparam logic REG_BLOCKS_IN_USE = 1'b0;

  // Item opcodes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Kind of result word that the datapath is to build.
  typedef enum logic [1:0] {
    RSP_OK    = 2'd0,
    RSP_FAIL  = 2'd1,
    RSP_ALLOC = 2'd2,
    RSP_READ  = 2'd3
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic mark;
    logic rsp;
    rsp_t rsp_kind;
  } ffa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;
    logic scan_end;
    logic scan_hit;
    logic mark_last;
  } ffa_sts_t;

endpackage

[src/first_fit_contiguous_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_contiguous_block_allocator: first-fit run allocator, chained table
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
// Usage
//   Items enter on start with in_opcode, in_run_length and in_entry_index;
//   a word is taken at a clock edge where start is high and busy is low.
//   Each item yields exactly one result word, shown for one cycle with
//   out_valid high. The receiver cannot stall; it must take every word.
//   A clear, a zero-length allocate or an unused opcode answers in the cycle
//   after it is taken; a read waits in ST_RDWAIT for the registered RAM read.
//   An allocate scans the allocated flags one block a cycle from block 0,
//   then writes the run into the link RAM one block a cycle.
//   The next item may be offered in the cycle its result is shown.
//   blocks_in_use sits at byte address 0 of the APB-style port; values above
//   BLOCK_COUNT act as BLOCK_COUNT. The user must see that blocks_in_use is
//   written only while the block is idle; the block does not enforce this.
//   Reset (rst_n low, synchronous) frees every block at once and loads
//   blocks_in_use with 128; link RAM entries are not reset, but a free block
//   reads as end of chain. There is no clearing pass; a clear acts at once.
// ----------------------------------------------------------------------------
module first_fit_contiguous_block_allocator import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Item channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_run_length,
  input  logic [6:0]        in_entry_index,
  // Result channel
  output logic              out_valid,
  output logic              out_status,
  output logic [6:0]        out_run_start,
  output logic [6:0]        out_run_end,
  output logic              out_entry_used,
  output logic signed [7:0] out_entry_link
);

  logic [7:0] blocks_in_use_r;
  logic       cfg_wr;
  ffa_cmd_t   cmd;
  ffa_sts_t   sts;

  // Configuration register write and read back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCKS_IN_USE);
  assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? {24'd0, blocks_in_use_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= BLOCKS_IN_USE_RST;
    end else if (cfg_wr) begin
      blocks_in_use_r <= pwdata[7:0];
    end
  end

  // Controller.
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Datapath.
  ffa_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .blocks_in_use  (blocks_in_use_r),
    .in_run_length  (in_run_length),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_run_start  (out_run_start),
    .out_run_end    (out_run_end),
    .out_entry_used (out_entry_used),
    .out_entry_link (out_entry_link)
  );

endmodule

[src/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[src/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator controller
// Sequences the clear, scan, mark and read steps and tells the datapath
// when to build a result word.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_opcode,
  input  ffa_sts_t   sts,
  output logic       busy,
  output ffa_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_MARK   = 4'b0100,
    ST_RDWAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rsp_kind = RSP_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_opcode)
            OP_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.rsp      = 1'b1;
              cmd.rsp_kind = RSP_OK;
            end
            OP_ALLOC: begin
              if (sts.len_zero) begin
                cmd.rsp      = 1'b1;
                cmd.rsp_kind = RSP_FAIL;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_READ: begin
              state_nxt = ST_RDWAIT;
            end
            default: begin
              cmd.rsp      = 1'b1;
              cmd.rsp_kind = RSP_FAIL;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          cmd.rsp      = 1'b1;
          cmd.rsp_kind = RSP_FAIL;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.scan_hit) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          cmd.rsp      = 1'b1;
          cmd.rsp_kind = RSP_ALLOC;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        cmd.rsp      = 1'b1;
        cmd.rsp_kind = RSP_READ;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // A scan leaves only to marking or, with a failure word, to idle.
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (state_r == ST_SCAN || state_r == ST_MARK ||
                              (state_r == ST_IDLE && $past(cmd.rsp_kind) == RSP_FAIL)))
    else $error("scan left by an unexpected path");

  // A read always issues its response command in the cycle after it was taken.
  a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && in_opcode == OP_READ) |=>
      (cmd.rsp && cmd.rsp_kind == RSP_READ))
    else $error("read item not answered on time");

  // Marking ends with exactly one allocation word.
  a_mark_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && sts.mark_last) |-> (cmd.rsp && cmd.rsp_kind == RSP_ALLOC))
    else $error("marking finished without a result word");

endmodule

[src/ffa_dpath.sv]
// ----------------------------------------------------------------------------
// ffa_dpath: allocator datapath
// Holds the allocated flags, the link RAM, the scan counters and the
// result word registers.
// ----------------------------------------------------------------------------
module ffa_dpath import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_cmd_t          cmd,
  output ffa_sts_t          sts,
  input  logic [7:0]        blocks_in_use,
  input  logic [7:0]        in_run_length,
  input  logic [6:0]        in_entry_index,
  output logic              out_valid,
  output logic              out_status,
  output logic [6:0]        out_run_start,
  output logic [6:0]        out_run_end,
  output logic              out_entry_used,
  output logic signed [7:0] out_entry_link
);

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Allocated flags: an entry is written only when it is allocated, so the
  // flag also tells whether the link RAM entry holds a value.
  logic [BLOCK_COUNT-1:0] used_r;

  cnt_t        j_r;
  cnt_t        count_r;
  blk_t        start_r;
  blk_t        last_r;
  blk_t        k_r;
  logic [7:0]  len_r;
  blk_t        idx_r;
  logic        idx_oob_r;
  logic        out_valid_r;

  logic [15:0]       n_blocks;
  logic              cur_free;
  cnt_t              count_inc;
  blk_t              cur_start;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  // Number of blocks managed, limited to the table size.
  assign n_blocks = (16'(blocks_in_use) > 16'(BLOCK_COUNT)) ? 16'(BLOCK_COUNT)
                                                            : 16'(blocks_in_use);

  // Scan step: one block a cycle.
  assign cur_free  = !used_r[j_r[BLK_W-1:0]];
  assign count_inc = count_r + cnt_t'(1);
  assign cur_start = (count_r == '0) ? j_r[BLK_W-1:0] : start_r;

  assign sts.len_zero  = (in_run_length == 8'd0);
  assign sts.scan_end  = (16'(j_r) >= n_blocks);
  assign sts.scan_hit  = cur_free && (16'(count_inc) == 16'(len_r));
  assign sts.mark_last = (k_r == last_r);

  // Link written at each marked block.
  assign ram_wdata = sts.mark_last ? LINK_END : LINK_W'(32'(k_r) + 1);

  ffa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (BLOCK_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.mark),
    .waddr (k_r),
    .wdata (ram_wdata),
    .raddr (BLK_W'(in_entry_index)),
    .rdata (ram_rdata)
  );

  // Item capture, scan counters and mark pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r     <= in_run_length;
      j_r       <= '0;
      count_r   <= '0;
      idx_r     <= BLK_W'(in_entry_index);
      idx_oob_r <= (16'(in_entry_index) >= 16'(BLOCK_COUNT));
    end
    if (cmd.scan) begin
      j_r <= j_r + cnt_t'(1);
      if (cur_free) begin
        count_r <= count_inc;
        start_r <= cur_start;
      end else begin
        count_r <= '0;
      end
      if (sts.scan_hit) begin
        k_r    <= cur_start;
        last_r <= j_r[BLK_W-1:0];
      end
    end
    if (cmd.mark) begin
      k_r <= k_r + blk_t'(1);
    end
  end

  // Allocated flags: cleared at once by reset or a clear item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.clear) begin
      used_r <= '0;
    end else if (cmd.mark) begin
      used_r[k_r] <= 1'b1;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rsp;
    end
  end

  // Result word; fields without meaning for the item are zero.
  always_ff @(posedge clk) begin
    if (cmd.rsp) begin
      case (cmd.rsp_kind)
        RSP_FAIL: begin
          out_status     <= 1'b1;
          out_run_start  <= '0;
          out_run_end    <= '0;
          out_entry_used <= 1'b0;
          out_entry_link <= '0;
        end
        RSP_ALLOC: begin
          out_status     <= 1'b0;
          out_run_start  <= 7'(start_r);
          out_run_end    <= 7'(last_r);
          out_entry_used <= 1'b0;
          out_entry_link <= '0;
        end
        RSP_READ: begin
          out_status     <= 1'b0;
          out_run_start  <= '0;
          out_run_end    <= '0;
          out_entry_used <= !idx_oob_r && used_r[idx_r];
          out_entry_link <= (idx_oob_r || !used_r[idx_r]) ? LINK_END : ram_rdata;
        end
        default: begin
          out_status     <= 1'b0;
          out_run_start  <= '0;
          out_run_end    <= '0;
          out_entry_used <= 1'b0;
          out_entry_link <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  // Marking only ever claims free blocks.
  a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> !used_r[k_r])
    else $error("marking an allocated block");

  // The mark pointer never runs past the end of the run.
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (k_r <= last_r))
    else $error("mark pointer beyond run end");

  // The free-run count never exceeds the blocks scanned.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (count_r <= j_r))
    else $error("run count larger than scan position");

  // An allocation word reports success on the next cycle.
  a_alloc_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rsp && cmd.rsp_kind == RSP_ALLOC) |=> (out_valid && !out_status))
    else $error("allocation word missing or flagged as failed");

endmodule

[sim/tb_first_fit_contiguous_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_block_allocator: self-checking bench for the allocator
// A short directed table walks the extremes of every field, each opcode and the
// corner cases. Random phases follow under several blocks_in_use settings.
// Every accepted word is run through a local model of the allocation table,
// and every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_block_allocator;
  import ffa_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic       ST_DONE   = 1'b0;
  localparam logic       ST_FAIL   = 1'b1;

  // Run limits.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * BLOCK_COUNT + 4;
  localparam int PHASE_ITEMS  = 145;
  localparam int PHASES       = 7;
  localparam int DIR_ROWS     = 20;
  localparam int PRINT_CAP    = 40;

  // One result word as the block presents it.
  typedef struct packed {
    logic       status;
    logic [6:0] run_start;
    logic [6:0] run_end;
    logic       entry_used;
    logic [7:0] entry_link;
  } alloc_word_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  len;
    logic [6:0]  idx;
    bit          typed;
    alloc_word_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [7:0]        in_run_length;
  logic [6:0]        in_entry_index;
  logic              out_valid;
  logic              out_status;
  logic [6:0]        out_run_start;
  logic [6:0]        out_run_end;
  logic              out_entry_used;
  logic signed [7:0] out_entry_link;

  // Local copy of the allocation table and the register.
  logic        blk_used [BLOCK_COUNT];
  logic [7:0]  blk_link [BLOCK_COUNT];
  logic [7:0]  blocks_cfg;

  alloc_word_t expected_words [$];
  alloc_word_t oldest_word;
  stim_row_t   directed_rows [DIR_ROWS];
  logic [7:0]  phase_cfg [PHASES];

  bit idle_on;
  int n_errors;
  int n_items;
  int n_checked;
  int n_granted;
  int n_refused;
  int n_settings;
  int stall_count;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_contiguous_block_allocator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_run_length  (in_run_length),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_run_start  (out_run_start),
    .out_run_end    (out_run_end),
    .out_entry_used (out_entry_used),
    .out_entry_link (out_entry_link)
  );

  // Number of blocks the allocator actually manages under the current setting.
  function automatic int managed_count();
    return (blocks_cfg > BLOCK_COUNT) ? BLOCK_COUNT : int'(blocks_cfg);
  endfunction

  // Applies one word to the local table and returns the result it should give.
  function automatic alloc_word_t predict_word(logic [1:0] op, logic [7:0] len,
                                               logic [6:0] idx);
    alloc_word_t w;
    int          managed;
    int          run;
    int          first;
    int          j;
    bit          found;
    w       = '0;
    managed = managed_count();
    run     = 0;
    first   = 0;
    found   = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (j = 0; j < BLOCK_COUNT; j++) begin
          blk_used[j] = 1'b0;
          blk_link[j] = LINK_END;
        end
      end
      OP_ALLOC: begin
        // First fit: the lowest run of len free blocks below the limit.
        if (len != 8'd0) begin
          for (j = 0; j < managed && !found; j++) begin
            if (!blk_used[j]) begin
              if (run == 0) first = j;
              run++;
              if (run == int'(len)) found = 1'b1;
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          for (j = first; j < first + int'(len); j++) begin
            blk_used[j] = 1'b1;
            blk_link[j] = (j == first + int'(len) - 1) ? LINK_END : 8'(j + 1);
          end
          w.run_start = 7'(first);
          w.run_end   = 7'(first + int'(len) - 1);
          n_granted++;
        end else begin
          w.status = ST_FAIL;
          n_refused++;
        end
      end
      OP_READ: begin
        w.entry_used = blk_used[idx];
        w.entry_link = blk_link[idx];
      end
      default: begin
        w.status = ST_FAIL;
      end
    endcase
    return w;
  endfunction

  // Chooses a random word, mostly allocates and reads aimed at the live table.
  function automatic void pick_item(output logic [1:0] op, output logic [7:0] len,
                                    output logic [6:0] idx);
    int managed;
    int free_blocks;
    int roll;
    int j;
    managed     = managed_count();
    free_blocks = 0;
    for (j = 0; j < managed; j++) begin
      if (!blk_used[j]) free_blocks++;
    end
    idx = 7'($urandom_range(0, 127));
    if (managed > 0 && $urandom_range(0, 3) != 0) idx = 7'($urandom_range(0, managed - 1));
    len  = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      op = OP_CLEAR;
    end else if (roll < 8) begin
      op = OP_UNUSED;
    end else if (roll < 50) begin
      op = OP_READ;
    end else begin
      op   = OP_ALLOC;
      roll = $urandom_range(0, 99);
      if (roll < 55) len = 8'($urandom_range(1, 8));
      else if (roll < 70) len = 8'($urandom_range(1, 32));
      else if (roll < 82) len = 8'((free_blocks > 0) ? free_blocks : 1);
      else if (roll < 87) len = 8'(free_blocks + 1);
      else if (roll < 95) len = 8'($urandom_range(0, 255));
      else len = 8'd0;
    end
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (n_errors < PRINT_CAP) begin
      $display("MISMATCH %s: got 0x%02h, want 0x%02h (word %0d, t=%0t)",
               what, got, want, n_checked, $realtime);
    end
    n_errors++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offers one word after an optional idle burst and records its prediction
  // once it is taken. The next drive always follows at the next falling edge.
  task automatic issue_item(logic [1:0] op, logic [7:0] len, logic [6:0] idx,
                            bit typed, alloc_word_t want);
    int          gap;
    alloc_word_t pred;
    gap = 0;
    if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_run_length  <= len;
    in_entry_index <= idx;
    do @(posedge clk); while (busy);
    pred = predict_word(op, len, idx);
    expected_words.push_back(typed ? want : pred);
    n_items++;
  endtask

  // Writes blocks_in_use once the allocator is idle, then reads it back.
  task automatic write_blocks_in_use(logic [7:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCKS_IN_USE, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    blocks_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("blocks_in_use read back", prdata[7:0], value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Result monitor: each word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none expected, status", 8'(out_status), 8'd0);
      end else begin
        oldest_word = expected_words.pop_front();
        check_field("status", 8'(out_status), 8'(oldest_word.status));
        check_field("run_start", 8'(out_run_start), 8'(oldest_word.run_start));
        check_field("run_end", 8'(out_run_end), 8'(oldest_word.run_end));
        check_field("entry_used", 8'(out_entry_used), 8'(oldest_word.entry_used));
        check_field("entry_link", out_entry_link, oldest_word.entry_link);
        n_checked++;
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no handshake at all.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles.", stall_count);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [1:0] op;
    logic [7:0] len;
    logic [6:0] idx;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    in_opcode      = OP_CLEAR;
    in_run_length  = '0;
    in_entry_index = '0;
    idle_on        = 1'b1;
    n_errors       = 0;
    n_items        = 0;
    n_checked      = 0;
    n_granted      = 0;
    n_refused      = 0;
    n_settings     = 0;
    stall_count    = 0;

    // Reset leaves the table as a clear does, with all 128 blocks managed.
    blocks_cfg = BLOCKS_IN_USE_RST;
    void'(predict_word(OP_CLEAR, 8'd0, 7'd0));

    // Directed table, run under the reset setting.
    directed_rows = '{
      '{OP_READ,   8'd0,   7'd0,   1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, LINK_END}},
      '{OP_READ,   8'd0,   7'd127, 1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, LINK_END}},
      '{OP_ALLOC,  8'd0,   7'd0,   1'b1, '{ST_FAIL, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_UNUSED, 8'd255, 7'd127, 1'b1, '{ST_FAIL, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_ALLOC,  8'd129, 7'd0,   1'b1, '{ST_FAIL, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_ALLOC,  8'd255, 7'd127, 1'b1, '{ST_FAIL, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_ALLOC,  8'd1,   7'd0,   1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_ALLOC,  8'd3,   7'd0,   1'b0, '0},
      '{OP_READ,   8'd0,   7'd1,   1'b0, '0},
      '{OP_READ,   8'd0,   7'd3,   1'b0, '0},
      '{OP_READ,   8'd0,   7'd0,   1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b1, LINK_END}},
      '{OP_ALLOC,  8'd124, 7'd0,   1'b0, '0},
      '{OP_ALLOC,  8'd1,   7'd0,   1'b0, '0},
      '{OP_READ,   8'd0,   7'd127, 1'b0, '0},
      '{OP_CLEAR,  8'd0,   7'd0,   1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_ALLOC,  8'd128, 7'd0,   1'b1, '{ST_DONE, 7'd0, 7'd127, 1'b0, 8'd0}},
      '{OP_READ,   8'd0,   7'd126, 1'b0, '0},
      '{OP_READ,   8'd170, 7'd85,  1'b0, '0},
      '{OP_CLEAR,  8'd255, 7'd127, 1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, 8'd0}},
      '{OP_READ,   8'd0,   7'd127, 1'b1, '{ST_DONE, 7'd0, 7'd0,   1'b0, LINK_END}}
    };

    // Settings for the random phases: none managed, one, above the table
    // size, all ones, a random one, two, and the full table.
    phase_cfg = '{8'd0, 8'd1, 8'd200, 8'd255, 8'd0, 8'd2, 8'd128};
    phase_cfg[4] = 8'($urandom_range(3, 127));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_item(directed_rows[i].op, directed_rows[i].len, directed_rows[i].idx,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases; the last one runs without idle gaps.
    for (int p = 0; p < PHASES; p++) begin
      write_blocks_in_use(phase_cfg[p]);
      idle_on = (p != PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_item(op, len, idx);
        issue_item(op, len, idx, 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words over %0d register settings; %0d result words checked.",
             n_items, n_settings, n_checked);
    $display("Allocations granted %0d, refused %0d; mismatches %0d.",
             n_granted, n_refused, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[first_fit_contiguous_block_allocator.f]
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_ctrl.sv
src/ffa_dpath.sv
src/first_fit_contiguous_block_allocator.sv
sim/tb_first_fit_contiguous_block_allocator.sv
